// File: src/ptmw_pkg.sv
// shared types, constants and helpers for the page table map walker
`default_nettype none

package ptmw_pkg;

	// pool size in table pages, root is page zero
	localparam int unsigned TABLE_PAGES = 64;

	localparam int unsigned IDX_W      = 9;
	localparam int unsigned ENTRIES    = 512;
	localparam int unsigned PAGE_SHIFT = 12;
	localparam int unsigned FRAME_W    = 40;
	localparam int unsigned VA_W       = 48;
	localparam int unsigned ENTRY_W    = 64;
	localparam int unsigned LEVEL_W    = 2;

	localparam int unsigned PAGE_W  = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
	localparam int unsigned NFP_W   = $clog2(TABLE_PAGES + 1);
	localparam int unsigned ADDR_W  = PAGE_W + IDX_W;
	localparam int unsigned DEPTH   = TABLE_PAGES * ENTRIES;

	localparam logic [ENTRY_W-1:0] KEEP_MASK = 64'hfff0_0000_0000_0fff;
	localparam logic [ENTRY_W-1:0] FLAG_PW   = 64'h0000_0000_0000_0003;

	// status codes
	localparam logic [1:0] ST_MAPPED   = 2'd0;
	localparam logic [1:0] ST_POOL_FULL = 2'd1;
	localparam logic [1:0] ST_OUTSIDE  = 2'd2;

	typedef struct packed {
		logic [VA_W-1:0]    virt_addr;
		logic [FRAME_W-1:0] phys_frame;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [1:0]         tables_allocated;
		logic [ENTRY_W-1:0] leaf_entry;
	} out_item_t;

	// keep flag bits, insert frame, set present and writable
	function automatic logic [ENTRY_W-1:0] with_frame(
		input logic [ENTRY_W-1:0] old,
		input logic [FRAME_W-1:0] frame
	);
		logic [ENTRY_W-1:0] addr_bits;
		addr_bits = {12'h000, frame, 12'h000};
		return (old & KEEP_MASK) | addr_bits | FLAG_PW;
	endfunction

endpackage

`default_nettype wire

// File: src/ptmw_table_ram.sv
// single port synchronous ram holding the table pool
`default_nettype none

module ptmw_table_ram #(
	parameter int unsigned DEPTH  = 32768,
	parameter int unsigned ADDR_W = 15,
	parameter int unsigned WIDTH  = 64
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] addr,
	input  wire logic [WIDTH-1:0]  wdata,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

`default_nettype wire

// File: src/ptmw_walk_ctrl.sv
// walk sequencer: clearing pass, four level read-modify-write walk, result hold
`default_nettype none

module ptmw_walk_ctrl (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                item_valid,
	output logic                                     item_ready,
	input  wire ptmw_pkg::in_item_t                  item,
	input  wire logic [ptmw_pkg::FRAME_W-1:0]        base_frame,
	output logic                                     res_valid,
	input  wire logic                                res_take,
	output ptmw_pkg::out_item_t                      res,
	output logic                                     ram_we,
	output logic                                     ram_re,
	output logic [ptmw_pkg::ADDR_W-1:0]              ram_addr,
	output logic [ptmw_pkg::ENTRY_W-1:0]             ram_wdata,
	input  wire logic [ptmw_pkg::ENTRY_W-1:0]        ram_rdata
);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_READ  = 3'd2;
	localparam logic [2:0] S_EVAL  = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	localparam logic [ptmw_pkg::NFP_W-1:0] POOL_FULL = ptmw_pkg::NFP_W'(ptmw_pkg::TABLE_PAGES);
	localparam logic [ptmw_pkg::ADDR_W-1:0] LAST_ADDR = ptmw_pkg::ADDR_W'(ptmw_pkg::DEPTH - 1);
	localparam logic [ptmw_pkg::LEVEL_W-1:0] LEAF_LEVEL = 2'd3;

	logic [2:0]                           state_q;
	logic [ptmw_pkg::ADDR_W-1:0]          clr_q;
	logic [ptmw_pkg::VA_W-1:0]            va_q;
	logic [ptmw_pkg::FRAME_W-1:0]         pf_q;
	logic [ptmw_pkg::LEVEL_W-1:0]         level_q;
	logic [ptmw_pkg::PAGE_W-1:0]          page_q;
	logic [ptmw_pkg::NFP_W-1:0]           nfp_q;
	logic [1:0]                           taken_q;
	logic [1:0]                           status_q;
	logic [ptmw_pkg::ENTRY_W-1:0]         leaf_q;

	logic [ptmw_pkg::IDX_W-1:0]           idx;
	logic                                 absent;
	logic                                 full;
	logic [ptmw_pkg::FRAME_W-1:0]         new_frame;
	logic [ptmw_pkg::FRAME_W-1:0]         rel;
	logic                                 outside;
	logic                                 last;
	logic [ptmw_pkg::ENTRY_W-1:0]         wr_entry;
	logic                                 eval_write;
	logic                                 clearing;

	always_comb begin
		unique case (level_q)
			2'd0: idx = va_q[47:39];
			2'd1: idx = va_q[38:30];
			2'd2: idx = va_q[29:21];
			2'd3: idx = va_q[20:12];
		endcase
	end

	assign absent    = ~ram_rdata[0];
	assign full      = (nfp_q >= POOL_FULL);
	assign new_frame = base_frame + ptmw_pkg::FRAME_W'(nfp_q);
	assign rel       = ram_rdata[51:12] - base_frame;
	assign outside   = (rel >= ptmw_pkg::FRAME_W'(nfp_q));
	assign last      = (level_q == LEAF_LEVEL);
	assign wr_entry  = last ? ptmw_pkg::with_frame(ram_rdata, pf_q)
	                        : ptmw_pkg::with_frame(ram_rdata, new_frame);
	assign eval_write = (state_q == S_EVAL) && (last || (absent && !full));
	assign clearing   = (state_q == S_CLEAR);

	assign ram_we    = clearing || eval_write;
	assign ram_re    = (state_q == S_READ);
	assign ram_addr  = clearing ? clr_q : {page_q, idx};
	assign ram_wdata = clearing ? '0 : wr_entry;

	assign item_ready = (state_q == S_IDLE);
	assign res_valid  = (state_q == S_DONE);
	assign res.status           = status_q;
	assign res.tables_allocated = taken_q;
	assign res.leaf_entry       = leaf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			nfp_q   <= ptmw_pkg::NFP_W'(1);
			level_q <= '0;
			page_q  <= '0;
			taken_q <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_ADDR) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (item_valid) begin
						level_q <= '0;
						page_q  <= '0;
						taken_q <= '0;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (last) begin
						state_q <= S_DONE;
					end else if (absent) begin
						if (full) begin
							state_q <= S_DONE;
						end else begin
							page_q  <= nfp_q[ptmw_pkg::PAGE_W-1:0];
							nfp_q   <= nfp_q + 1'b1;
							taken_q <= taken_q + 1'b1;
							level_q <= level_q + 1'b1;
							state_q <= S_READ;
						end
					end else if (outside) begin
						state_q <= S_DONE;
					end else begin
						page_q  <= rel[ptmw_pkg::PAGE_W-1:0];
						level_q <= level_q + 1'b1;
						state_q <= S_READ;
					end
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

	// payload side, no reset
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && item_valid) begin
			va_q <= item.virt_addr;
			pf_q <= item.phys_frame;
		end
		if (state_q == S_EVAL) begin
			if (last) begin
				status_q <= ptmw_pkg::ST_MAPPED;
				leaf_q   <= wr_entry;
			end else if (absent && full) begin
				status_q <= ptmw_pkg::ST_POOL_FULL;
				leaf_q   <= '0;
			end else if (!absent && outside) begin
				status_q <= ptmw_pkg::ST_OUTSIDE;
				leaf_q   <= '0;
			end
		end
	end

endmodule

`default_nettype wire

// File: src/page_table_map_walker.sv
// top level: four level page table map walker over an on-chip table pool
// walk: each level takes a read state and an evaluate/write state on the single ram port,
//   then the result waits in the result hold state until the output register takes it;
//   an early stop (pool full or entry outside the pool) skips the remaining levels
// throughput: one item at a time, next item taken once the result has moved out
// reset: the table ram is cleared, all TABLE_PAGES*512 entries (32768), before the first item
`default_nettype none

module page_table_map_walker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire ptmw_pkg::in_item_t             in_data,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output ptmw_pkg::out_item_t                 out_data,
	input  wire logic                           cfg_we,
	input  wire logic [ptmw_pkg::FRAME_W-1:0]   cfg_wdata
);

	// pool base frame register
	logic [ptmw_pkg::FRAME_W-1:0] base_q;

	// walker to ram
	logic                          ram_we;
	logic                          ram_re;
	logic [ptmw_pkg::ADDR_W-1:0]   ram_addr;
	logic [ptmw_pkg::ENTRY_W-1:0]  ram_wdata;
	logic [ptmw_pkg::ENTRY_W-1:0]  ram_rdata;

	// walker result hand-off
	logic                          item_ready;
	logic                          res_valid;
	logic                          res_take;
	ptmw_pkg::out_item_t           res;

	// output register
	logic                          out_valid_q;
	ptmw_pkg::out_item_t           out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg_we) begin
			base_q <= cfg_wdata;
		end
	end

	assign in_stall = !item_ready;

	ptmw_walk_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (in_valid),
		.item_ready (item_ready),
		.item       (in_data),
		.base_frame (base_q),
		.res_valid  (res_valid),
		.res_take   (res_take),
		.res        (res),
		.ram_we     (ram_we),
		.ram_re     (ram_re),
		.ram_addr   (ram_addr),
		.ram_wdata  (ram_wdata),
		.ram_rdata  (ram_rdata)
	);

	ptmw_table_ram #(
		.DEPTH  (ptmw_pkg::DEPTH),
		.ADDR_W (ptmw_pkg::ADDR_W),
		.WIDTH  (ptmw_pkg::ENTRY_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// output slot is free when empty or being taken this cycle
	assign res_take = res_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, held while stalled
	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire
